// ===== src/cad_pkg.sv =====
// Shared types and codes for the circular array deque.
`default_nettype none

package cad_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell of one chain. Index 0 of a chain is its port end.
  typedef struct packed {
    logic  insert;  // shift away from the port, the port cell takes value
    logic  remove;  // shift toward the port
    logic  append;  // first empty cell after the occupied run takes value
    logic  drop;    // last occupied cell is cleared
    word_t value;
  } chain_cmd_t;

endpackage

`default_nettype wire

// ===== src/cad_cell.sv =====
// One storage cell of a deque chain: a word and its valid bit, fed by its two neighbors.
`default_nettype none

module cad_cell (
  input  wire                clk,
  input  wire                rst,
  input  cad_pkg::chain_cmd_t cmd,
  input  wire                near_valid,
  input  cad_pkg::word_t     near_data,
  input  wire                far_valid,
  input  cad_pkg::word_t     far_data,
  output logic               valid,
  output cad_pkg::word_t     data
);
  import cad_pkg::*;

  logic  valid_next;
  word_t data_next;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (cmd.insert) begin
      valid_next = near_valid;
      data_next  = near_data;
    end else if (cmd.remove) begin
      valid_next = far_valid;
      data_next  = far_data;
    end else if (cmd.append && !valid && near_valid) begin
      valid_next = 1'b1;
      data_next  = cmd.value;
    end else if (cmd.drop && valid && !far_valid) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // The word itself needs no reset: it is only ever read while valid.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== src/cad_chain.sv =====
// A row of deque cells with the port at cell 0; each cell talks only to its neighbors.
`default_nettype none

module cad_chain #(
  parameter int DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cad_pkg::chain_cmd_t cmd,
  output cad_pkg::word_t      port_data
);
  import cad_pkg::*;

  logic  cell_valid [DEPTH];
  word_t cell_data  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic  near_valid;
    word_t near_data;
    logic  far_valid;
    word_t far_data;

    // The port cell sees the incoming word as an always-valid near neighbor.
    if (k == 0) begin : g_port
      assign near_valid = 1'b1;
      assign near_data  = cmd.value;
    end else begin : g_inner
      assign near_valid = cell_valid[k-1];
      assign near_data  = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_end
      assign far_valid = 1'b0;
      assign far_data  = '0;
    end else begin : g_mid
      assign far_valid = cell_valid[k+1];
      assign far_data  = cell_data[k+1];
    end

    cad_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .near_valid (near_valid),
      .near_data  (near_data),
      .far_valid  (far_valid),
      .far_data   (far_data),
      .valid      (cell_valid[k]),
      .data       (cell_data[k])
    );
  end

  assign port_data = cell_data[0];

endmodule

`default_nettype wire

// ===== src/circular_array_deque_top.sv =====
// Top level of the double-ended queue of signed 32-bit words.
//
// Usage: one transaction on the item channel (item_valid, item_stall, operation,
// push_value) asks for push front, push rear, pop front, pop rear, peek front or
// peek rear. Each item yields exactly one transaction on the result channel
// (result_valid, result_stall, result_value, status, is_full, is_empty), in order.
// The flags show the queue as it stands after the item.
// The result is registered at the edge that accepts the item.
// Throughput is one item per cycle while no stalled result blocks the item channel, set by the
// cell chains, whose cells all update together in one clock from their neighbors' contents.
// While the result register holds a result the receiver stalls, item_stall rises
// and the held result keeps its value until it is taken; as soon as it is taken a
// new item may be accepted in the same cycle.
// Reset (rst, synchronous) empties the queue and drops any pending result; the
// stored words themselves are not cleared, only their valid bits.
// Inside, two chains of DEPTH cells hold the same sequence: one keeps the front at
// its cell 0, the other keeps the rear at its cell 0, so both ends read from a
// fixed cell. A push to a full queue or a pop or peek on an empty one is rejected
// and leaves the queue unchanged.
`default_nettype none

module circular_array_deque_top #(
  parameter int DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  wire  [2:0]          operation,
  input  cad_pkg::word_t      push_value,
  output logic                result_valid,
  input  wire                 result_stall,
  output cad_pkg::word_t      result_value,
  output logic [1:0]          status,
  output logic                is_full,
  output logic                is_empty
);
  import cad_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0] entry_count;
  logic [CW-1:0] entry_count_next;

  logic       accept;
  logic       full;
  logic       empty;
  word_t      front_word;
  word_t      rear_word;
  word_t      res_next;
  status_t    st_next;
  chain_cmd_t cmd_front;
  chain_cmd_t cmd_rear;
  logic       result_valid_next;

  // A new item may enter whenever the result register is free or being emptied.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign full  = (entry_count == FULL_COUNT);
  assign empty = (entry_count == '0);

  always_comb begin
    res_next         = '0;
    st_next          = ST_OK;
    entry_count_next = entry_count;
    cmd_front        = '0;
    cmd_rear         = '0;
    cmd_front.value  = push_value;
    cmd_rear.value   = push_value;

    case (op_t'(operation))
      OP_PUSH_FRONT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          cmd_front.insert = 1'b1;
          cmd_rear.append  = 1'b1;
          entry_count_next = entry_count + CW'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          cmd_rear.insert  = 1'b1;
          cmd_front.append = 1'b1;
          entry_count_next = entry_count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          res_next         = front_word;
          cmd_front.remove = 1'b1;
          cmd_rear.drop    = 1'b1;
          entry_count_next = entry_count - CW'(1);
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          res_next         = rear_word;
          cmd_rear.remove  = 1'b1;
          cmd_front.drop   = 1'b1;
          entry_count_next = entry_count - CW'(1);
        end
      end
      OP_PEEK_FRONT: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          res_next = front_word;
        end
      end
      OP_PEEK_REAR: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          res_next = rear_word;
        end
      end
      default: begin
        // Unused operation codes leave the queue alone and report ok.
      end
    endcase

    // Nothing moves in the chains unless an item is actually taken.
    if (!accept) begin
      cmd_front.insert = 1'b0;
      cmd_front.remove = 1'b0;
      cmd_front.append = 1'b0;
      cmd_front.drop   = 1'b0;
      cmd_rear.insert  = 1'b0;
      cmd_rear.remove  = 1'b0;
      cmd_rear.append  = 1'b0;
      cmd_rear.drop    = 1'b0;
      entry_count_next = entry_count;
    end
  end

  cad_chain #(.DEPTH(DEPTH)) u_front_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_front),
    .port_data (front_word)
  );

  cad_chain #(.DEPTH(DEPTH)) u_rear_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_rear),
    .port_data (rear_word)
  );

  always_comb begin
    if (accept) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      entry_count  <= entry_count_next;
      result_valid <= result_valid_next;
    end
  end

  // The result payload loads only on an accepted transaction and otherwise holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_value <= res_next;
      status       <= st_next;
      is_full      <= (entry_count_next == FULL_COUNT);
      is_empty     <= (entry_count_next == '0);
    end
  end

endmodule

`default_nettype wire

// ===== src/cad_checker.sv =====
// Port-level checks on the deque top level, bound to it.
`default_nettype none

module cad_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 item_valid,
  input wire                 item_stall,
  input wire                 result_valid,
  input wire                 result_stall,
  input cad_pkg::word_t      result_value,
  input wire  [1:0]          status,
  input wire                 is_full,
  input wire                 is_empty
);
  import cad_pkg::*;

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result still valid after reset");

  // Every accepted transaction leaves a result waiting in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("accepted transaction produced no result");

  // A stalled result stays and holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(result_value) && $stable(status))
    else $error("stalled result changed");

  // The queue can never be full and empty at once.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(is_full && is_empty))
    else $error("full and empty flags both set");

  // A rejection matches the flags: full rejects show full, empty rejects show empty and zero.
  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (status != ST_FULL || is_full) &&
      (status != ST_EMPTY || (is_empty && result_value == '0)))
    else $error("rejection status disagrees with flags");

endmodule

bind circular_array_deque_top cad_checker u_cad_checker (.*);

`default_nettype wire
